// ----- sv/jsep_pkg.sv -----
// ----------------------------------------------------------------------------
// jsep_pkg
// Shared types and constants for the Julia-set escape pixel block.
// ----------------------------------------------------------------------------
package jsep_pkg;

  // Width of one complex component (signed fixed point).
  localparam int ZW = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_C_REAL        = 2'd0,
    REG_C_IMAG        = 2'd1,
    REG_ESCAPE_RADIUS = 2'd2,
    REG_MAX_DEPTH     = 2'd3
  } reg_idx_t;

  // Control state of the pixel sequencer.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MAP  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_STEP = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Start and completion strobes between the sequencer and a serial unit.
  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic done;
  } unit_stat_t;

endpackage

// ----- sv/jsep_coord_map.sv -----
// ----------------------------------------------------------------------------
// jsep_coord_map
// Maps a pixel coordinate to a fixed-point component by bit-serial long
// division of |p - W/2| * 2r * 2^F by W, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jsep_coord_map #(
  parameter int IMAGE_SIZE = 1024,
  parameter int FRAC_BITS  = 28
) (
  input  logic                        clk,
  input  logic                        rst,
  input  jsep_pkg::unit_ctrl_t        ctrl,
  input  logic [9:0]                  p,
  input  logic [2:0]                  r,
  output jsep_pkg::unit_stat_t        stat,
  output logic signed [jsep_pkg::ZW-1:0] z
);

  localparam int ZW   = jsep_pkg::ZW;
  localparam int HALF = IMAGE_SIZE / 2;
  localparam int LW   = ($clog2(IMAGE_SIZE) > 10) ? $clog2(IMAGE_SIZE) : 10;
  localparam int DW   = LW + 1;
  localparam int MW   = DW + 4;
  localparam int NB   = MW + FRAC_BITS;
  localparam int CNW  = $clog2(NB + 1);
  localparam int RW   = $clog2(IMAGE_SIZE) + 1;

  logic signed [DW-1:0] dv;
  logic [DW-1:0]        dmag;
  logic [MW-1:0]        m;
  logic [MW-1:0]        nsh;
  logic [RW-2:0]        rem;
  logic [RW-1:0]        rem2;
  logic                 ge;
  logic [ZW:0]          q;
  logic                 sat;
  logic                 neg;
  logic                 busy;
  logic [CNW-1:0]       cnt;
  logic                 big;

  // Offset from the image centre and the scaled magnitude.
  assign dv   = $signed(DW'(p)) - $signed(DW'(HALF));
  assign dmag = dv[DW-1] ? DW'(-dv) : DW'(dv);
  assign m    = MW'(dmag) * MW'({r, 1'b0});

  // One restoring division step per cycle.
  assign rem2 = {rem, nsh[MW-1]};
  assign ge   = rem2 >= RW'(IMAGE_SIZE);
  assign big  = sat | q[ZW] | q[ZW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= busy && !ctrl.start && (cnt == CNW'(NB - 1));
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        nsh  <= m;
        neg  <= dv[DW-1];
        rem  <= '0;
        q    <= '0;
        sat  <= 1'b0;
      end else if (busy) begin
        nsh <= {nsh[MW-2:0], 1'b0};
        rem <= ge ? (RW-1)'(rem2 - RW'(IMAGE_SIZE)) : rem2[RW-2:0];
        sat <= sat | q[ZW];
        q   <= {q[ZW-1:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(NB - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Saturate the quotient and apply the sign.
  always_comb begin
    if (neg) begin
      z = big ? {1'b1, {(ZW-1){1'b0}}} : $signed(-q[ZW-1:0]);
    end else begin
      z = big ? {1'b0, {(ZW-1){1'b1}}} : $signed(q[ZW-1:0]);
    end
  end

  // Assertions.
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !busy) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> busy) else $error("start did not begin division");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt < CNW'(NB)) else $error("division counter overran");

endmodule

// ----- sv/jsep_sqr_unit.sv -----
// ----------------------------------------------------------------------------
// jsep_sqr_unit
// Bit-serial shift-add multiplier forming a*a, b*b and a*b from unsigned
// magnitudes, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module jsep_sqr_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  jsep_pkg::unit_ctrl_t         ctrl,
  input  logic [jsep_pkg::ZW-1:0]      a,
  input  logic [jsep_pkg::ZW-1:0]      b,
  output jsep_pkg::unit_stat_t         stat,
  output logic [2*jsep_pkg::ZW-1:0]    aa,
  output logic [2*jsep_pkg::ZW-1:0]    bb,
  output logic [2*jsep_pkg::ZW-1:0]    ab
);

  localparam int ZW  = jsep_pkg::ZW;
  localparam int CNW = $clog2(ZW);

  logic [ZW-1:0]  ma, mb, ra, rb;
  logic           busy;
  logic [CNW-1:0] cnt;
  logic [ZW:0]    s_aa, s_bb, s_ab;

  // Partial sums of the upper half for this multiplier bit.
  assign s_aa = {1'b0, aa[2*ZW-1:ZW]} + (ma[0] ? {1'b0, ra} : '0);
  assign s_bb = {1'b0, bb[2*ZW-1:ZW]} + (mb[0] ? {1'b0, rb} : '0);
  assign s_ab = {1'b0, ab[2*ZW-1:ZW]} + (mb[0] ? {1'b0, ra} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= busy && !ctrl.start && (cnt == CNW'(ZW - 1));
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ra   <= a;
        rb   <= b;
        ma   <= a;
        mb   <= b;
        aa   <= '0;
        bb   <= '0;
        ab   <= '0;
      end else if (busy) begin
        aa  <= {s_aa, aa[ZW-1:1]};
        bb  <= {s_bb, bb[ZW-1:1]};
        ab  <= {s_ab, ab[ZW-1:1]};
        ma  <= {1'b0, ma[ZW-1:1]};
        mb  <= {1'b0, mb[ZW-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(ZW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Assertions.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> busy) else $error("multiply did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !busy) else $error("done while busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !ctrl.start) else $error("restart during multiply");

endmodule

// ----- sv/julia_set_escape_pixel.sv -----
// ----------------------------------------------------------------------------
// julia_set_escape_pixel
// Julia-set escape-time test for one pixel with an APB register port.
// ----------------------------------------------------------------------------
// A pixel transaction (pixel_x, pixel_y) enters on in_valid/in_ready. The
// block maps it to z0, then repeatedly squares z and adds c, testing
// |z|^2 > r^2 before each step. One result transaction (color, painted)
// leaves on out_valid/out_ready for every pixel.
// A pixel outside the image disk goes straight to the result load. Any
// other pixel runs the serial coordinate divider and then, for each
// escape test, the bit-serial multiplier, before its result is loaded;
// the test count is at most max_depth - floor(max_depth/4) + 2. One pixel
// is in work at a time.
// The result sits in an output register, so a new pixel is accepted while
// the previous result waits; if the receiver stalls when the next result
// is ready, the block holds it until the output register frees.
// Reset clears the control state and returns the registers to c =
// (-71672268, -164014066), escape_radius 2 and max_depth 50. Registers must
// be written by the user only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module julia_set_escape_pixel #(
  parameter int IMAGE_SIZE = 1024,
  parameter int FRAC_BITS  = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  color,
  output logic        painted,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ZW   = jsep_pkg::ZW;
  localparam int HALF = IMAGE_SIZE / 2;
  localparam int LW   = ($clog2(IMAGE_SIZE) > 10) ? $clog2(IMAGE_SIZE) : 10;
  localparam int DW   = LW + 1;
  localparam int QW   = 2 * DW + 1;
  localparam int CW   = (2 * FRAC_BITS + 6 > 2 * ZW + 1) ? 2 * FRAC_BITS + 6 : 2 * ZW + 1;
  localparam int SW   = 2 * ZW + 3;
  localparam logic [3:0] COLOR_WHITE = 4'd15;
  localparam logic [3:0] COLOR_BLACK = 4'd0;

  // Configuration registers.
  logic signed [ZW-1:0] c_real, c_imag;
  logic [2:0]           escape_radius;
  logic [9:0]           max_depth;
  jsep_pkg::reg_idx_t   widx;

  assign pready = 1'b1;
  assign widx   = jsep_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real        <= -32'sd71672268;
      c_imag        <= -32'sd164014066;
      escape_radius <= 3'd2;
      max_depth     <= 10'd50;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        jsep_pkg::REG_C_REAL:        c_real        <= pwdata;
        jsep_pkg::REG_C_IMAG:        c_imag        <= pwdata;
        jsep_pkg::REG_ESCAPE_RADIUS: escape_radius <= pwdata[2:0];
        jsep_pkg::REG_MAX_DEPTH:     max_depth     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (widx)
      jsep_pkg::REG_C_REAL:        prdata = c_real;
      jsep_pkg::REG_C_IMAG:        prdata = c_imag;
      jsep_pkg::REG_ESCAPE_RADIUS: prdata = {29'd0, escape_radius};
      jsep_pkg::REG_MAX_DEPTH:     prdata = {22'd0, max_depth};
      default:                     prdata = '0;
    endcase
  end

  // Disk test on the incoming pixel.
  logic signed [DW-1:0] dx, dy;
  logic [QW-1:0]        dist2;
  logic                 outside_in;

  assign dx         = $signed(DW'(pixel_x)) - $signed(DW'(HALF));
  assign dy         = $signed(DW'(pixel_y)) - $signed(DW'(HALF));
  assign dist2      = QW'($unsigned(QW'(dx) * QW'(dx))) + QW'($unsigned(QW'(dy) * QW'(dy)));
  assign outside_in = dist2 > QW'(HALF * HALF);

  // Sequencer state.
  jsep_pkg::state_t     state;
  logic [9:0]           px, py;
  logic signed [ZW-1:0] zr, zi;
  logic [10:0]          left;
  logic                 esc, outside;
  jsep_pkg::unit_ctrl_t map_ctrl, mul_ctrl;
  jsep_pkg::unit_stat_t mapx_stat, mapy_stat, mul_stat;
  logic signed [ZW-1:0] zx0, zy0;
  logic [ZW-1:0]        zr_mag, zi_mag;
  logic [2*ZW-1:0]      p_aa, p_bb, p_ab;

  assign in_ready = state == jsep_pkg::ST_IDLE;

  jsep_coord_map #(.IMAGE_SIZE(IMAGE_SIZE), .FRAC_BITS(FRAC_BITS)) u_map_x (
    .clk(clk), .rst(rst), .ctrl(map_ctrl), .p(px), .r(escape_radius),
    .stat(mapx_stat), .z(zx0)
  );

  jsep_coord_map #(.IMAGE_SIZE(IMAGE_SIZE), .FRAC_BITS(FRAC_BITS)) u_map_y (
    .clk(clk), .rst(rst), .ctrl(map_ctrl), .p(py), .r(escape_radius),
    .stat(mapy_stat), .z(zy0)
  );

  assign zr_mag = zr[ZW-1] ? ZW'(-zr) : ZW'(zr);
  assign zi_mag = zi[ZW-1] ? ZW'(-zi) : ZW'(zi);

  jsep_sqr_unit u_sqr (
    .clk(clk), .rst(rst), .ctrl(mul_ctrl), .a(zr_mag), .b(zi_mag),
    .stat(mul_stat), .aa(p_aa), .bb(p_bb), .ab(p_ab)
  );

  // Escape compare and one step z = z*z + c.
  function automatic logic signed [ZW-1:0] sat_z(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] vmax, vmin;
    vmax = $signed({{(SW-ZW+1){1'b0}}, {(ZW-1){1'b1}}});
    vmin = $signed({{(SW-ZW+1){1'b1}}, {(ZW-1){1'b0}}});
    if (v > vmax) begin
      sat_z = vmax[ZW-1:0];
    end else if (v < vmin) begin
      sat_z = vmin[ZW-1:0];
    end else begin
      sat_z = v[ZW-1:0];
    end
  endfunction

  logic [2*ZW:0]        sum2;
  logic [5:0]           r2;
  logic                 esc_now;
  logic                 re_neg, im_neg;
  logic [2*ZW-1:0]      re_mag;
  logic [2*ZW:0]        im_mag;
  logic signed [SW-1:0] re_s, im_s;
  logic signed [ZW-1:0] zr_new, zi_new;

  assign sum2    = {1'b0, p_aa} + {1'b0, p_bb};
  assign r2      = 6'(escape_radius) * 6'(escape_radius);
  assign esc_now = CW'(sum2) > (CW'(r2) << (2 * FRAC_BITS));
  assign re_neg  = p_aa < p_bb;
  assign re_mag  = re_neg ? p_bb - p_aa : p_aa - p_bb;
  assign im_mag  = {p_ab, 1'b0};
  assign im_neg  = zr[ZW-1] ^ zi[ZW-1];

  always_comb begin
    re_s = $signed(SW'(re_mag >> FRAC_BITS));
    im_s = $signed(SW'(im_mag >> FRAC_BITS));
    if (re_neg) begin
      re_s = -re_s;
    end
    if (im_neg) begin
      im_s = -im_s;
    end
    zr_new = sat_z(re_s + SW'(c_real));
    zi_new = sat_z(im_s + SW'(c_imag));
  end

  // Pixel sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= jsep_pkg::ST_IDLE;
      map_ctrl.start <= 1'b0;
      mul_ctrl.start <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      map_ctrl.start <= (state == jsep_pkg::ST_IDLE) && in_valid && !outside_in;
      mul_ctrl.start <= ((state == jsep_pkg::ST_MAP) && mapx_stat.done) ||
                        ((state == jsep_pkg::ST_STEP) && !esc_now && (left != 11'd1));
      if ((state != jsep_pkg::ST_DONE) && out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        jsep_pkg::ST_IDLE: begin
          if (in_valid) begin
            px      <= pixel_x;
            py      <= pixel_y;
            outside <= outside_in;
            esc     <= 1'b0;
            if (outside_in) begin
              state <= jsep_pkg::ST_DONE;
            end else begin
              state <= jsep_pkg::ST_MAP;
            end
          end
        end
        jsep_pkg::ST_MAP: begin
          if (mapx_stat.done) begin
            zr    <= zx0;
            zi    <= zy0;
            left  <= 11'(max_depth) - 11'(max_depth >> 2) + 11'd2;
            state <= jsep_pkg::ST_MUL;
          end
        end
        jsep_pkg::ST_MUL: begin
          if (mul_stat.done) begin
            state <= jsep_pkg::ST_STEP;
          end
        end
        jsep_pkg::ST_STEP: begin
          if (esc_now) begin
            esc   <= 1'b1;
            state <= jsep_pkg::ST_DONE;
          end else if (left == 11'd1) begin
            state <= jsep_pkg::ST_DONE;
          end else begin
            zr    <= zr_new;
            zi    <= zi_new;
            left  <= left - 11'd1;
            state <= jsep_pkg::ST_MUL;
          end
        end
        jsep_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            painted   <= outside | esc;
            color     <= (!outside && esc) ? COLOR_WHITE : COLOR_BLACK;
            state     <= jsep_pkg::ST_IDLE;
          end
        end
        default: state <= jsep_pkg::ST_IDLE;
      endcase
    end
  end

  // Assertions.
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == jsep_pkg::ST_MAP || state == jsep_pkg::ST_DONE))
    else $error("accepted pixel not taken into work");
  a_unpainted_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !painted) |-> color == COLOR_BLACK) else $error("unpainted pixel coloured");
  a_mul_to_step: assert property (@(posedge clk) disable iff (rst)
    (state == jsep_pkg::ST_MUL && mul_stat.done) |=> state == jsep_pkg::ST_STEP)
    else $error("multiply result not used");
  a_maps_agree: assert property (@(posedge clk) disable iff (rst)
    mapx_stat.done == mapy_stat.done) else $error("coordinate units out of step");
  a_tests_left: assert property (@(posedge clk) disable iff (rst)
    state == jsep_pkg::ST_STEP |-> left != 11'd0) else $error("test count ran out");

endmodule

// ----- sim/julia_set_escape_pixel_tb.sv -----
// ----------------------------------------------------------------------------
// julia_set_escape_pixel_tb
// Self-checking bench for the Julia-set escape pixel block. A short table of
// directed pixels runs under a few fixed register settings. Random phases
// follow, each under its own random setting. A bit-exact fixed-point
// predictor gives the colour and painted flag of each untyped pixel.
// ----------------------------------------------------------------------------
module julia_set_escape_pixel_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     IMG      = 1024;
  localparam int     FB       = 28;
  localparam int     LIMIT    = 100000;
  localparam longint SAT_MAX  = 64'sd2147483647;
  localparam longint SAT_MIN  = -64'sd2147483648;

  typedef struct {
    logic [3:0] color;
    logic       painted;
  } pix_res_t;

  typedef struct {
    logic [31:0] c_re;
    logic [31:0] c_im;
    logic [2:0]  radius;
    logic [9:0]  depth;
  } jset_cfg_t;

  typedef struct {
    int         cfg_id;
    bit [9:0]   x;
    bit [9:0]   y;
    bit         typed;
    logic [3:0] color;
    logic       painted;
  } pix_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [9:0]  pixel_x = '0;
  logic [9:0]  pixel_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  color;
  logic        painted;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Outputs sampled mid-cycle so that edge-time updates cannot race the bench.
  logic        in_ready_s, out_valid_s, pready_s;
  logic [3:0]  color_s;
  logic        painted_s;

  jset_cfg_t   cur_cfg;
  pix_res_t    expected_pixels[$];
  bit          failed   = 1'b0;
  bit          idle_on  = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  julia_set_escape_pixel u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .color(color), .painted(painted),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    in_ready_s  <= in_ready;
    out_valid_s <= out_valid;
    pready_s    <= pready;
    color_s     <= color;
    painted_s   <= painted;
  end

  // Map one pixel coordinate to a Q3.28 component, truncated and saturated.
  function automatic longint map_axis(bit [9:0] p, bit [2:0] r);
    longint          d;
    longint unsigned m;
    longint unsigned q;
    d = longint'(p) - IMG / 2;
    m = longint'(d < 0 ? -d : d) * (2 * r);
    q = (m << FB) / IMG;
    if (d < 0) return (q >= 64'd2147483648) ? SAT_MIN : -longint'(q);
    return (q > 64'd2147483647) ? SAT_MAX : longint'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  // Escape-time prediction for one pixel under the current registers.
  function automatic pix_res_t predict_pixel(bit [9:0] px, bit [9:0] py);
    pix_res_t        res;
    longint          zr, zi, cr, ci, dx, dy, re, im;
    longint unsigned a, b, a2, b2, sum, r2;
    int              tests;
    bit              esc, outside;
    zr    = map_axis(px, cur_cfg.radius);
    zi    = map_axis(py, cur_cfg.radius);
    cr    = longint'($signed(cur_cfg.c_re));
    ci    = longint'($signed(cur_cfg.c_im));
    r2    = cur_cfg.radius * cur_cfg.radius;
    tests = cur_cfg.depth - cur_cfg.depth / 4 + 2;
    esc   = 1'b0;
    for (int t = 0; t < tests; t++) begin
      a   = zr < 0 ? -zr : zr;
      b   = zi < 0 ? -zi : zi;
      a2  = a * a;
      b2  = b * b;
      sum = a2 + b2;
      if ((r2 == 0) ? (sum > 0) : (sum > (r2 << (2 * FB)))) begin
        esc = 1'b1;
        break;
      end
      re = (a2 >= b2) ? longint'((a2 - b2) >> FB) : -longint'((b2 - a2) >> FB);
      im = longint'((2 * a * b) >> FB);
      if ((zr < 0) != (zi < 0)) im = -im;
      zr = sat32(re + cr);
      zi = sat32(im + ci);
    end
    dx      = longint'(px) - IMG / 2;
    dy      = longint'(py) - IMG / 2;
    outside = (dx * dx + dy * dy) > (IMG / 2) * (IMG / 2);
    if (outside) begin
      res.color = 4'd0;  res.painted = 1'b1;
    end else if (esc) begin
      res.color = 4'd15; res.painted = 1'b1;
    end else begin
      res.color = 4'd0;  res.painted = 1'b0;
    end
    return res;
  endfunction

  // One APB write: setup cycle, then access cycle.
  task automatic write_reg(jsep_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready_s);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      jsep_pkg::REG_C_REAL:        cur_cfg.c_re   = val;
      jsep_pkg::REG_C_IMAG:        cur_cfg.c_im   = val;
      jsep_pkg::REG_ESCAPE_RADIUS: cur_cfg.radius = val[2:0];
      jsep_pkg::REG_MAX_DEPTH:     cur_cfg.depth  = val[9:0];
      default: ;
    endcase
  endtask

  // Registers change only once every pixel in flight has been answered.
  task automatic load_setting(jset_cfg_t s);
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(jsep_pkg::REG_C_REAL, s.c_re);
    write_reg(jsep_pkg::REG_C_IMAG, s.c_im);
    write_reg(jsep_pkg::REG_ESCAPE_RADIUS, 32'(s.radius));
    write_reg(jsep_pkg::REG_MAX_DEPTH, 32'(s.depth));
  endtask

  // Offer one pixel and queue its expected result once accepted.
  task automatic send_pixel(bit [9:0] x, bit [9:0] y, bit typed,
                            logic [3:0] ec, logic ep);
    pix_res_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    do @(posedge clk); while (!in_ready_s);
    if (typed) begin
      r.color = ec; r.painted = ep;
    end else begin
      r = predict_pixel(x, y);
    end
    expected_pixels.push_back(r);
  endtask

  // Receiver with random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check against the oldest expected pixel.
  always @(posedge clk) begin
    pix_res_t e;
    if (!rst && out_valid_s && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with nothing expected: color %0d painted %0d",
                 $realtime, color_s, painted_s);
        failed = 1'b1;
      end else begin
        e = expected_pixels.pop_front();
        if (color_s !== e.color) begin
          $display("%0t: color expected %0d actual %0d",
                   $realtime, e.color, color_s);
          failed = 1'b1;
        end
        if (painted_s !== e.painted) begin
          $display("%0t: painted expected %0d actual %0d",
                   $realtime, e.painted, painted_s);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if ((in_valid && in_ready_s) || (out_valid_s && out_ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Main sequence: directed table, then random phases.
  initial begin
    jset_cfg_t dir_cfgs[4];
    pix_row_t  rows[$];
    jset_cfg_t s;
    int        cur_id;
    bit [9:0]  x, y;

    dir_cfgs[0] = '{32'hFBBA_5E34, 32'hF639_580E, 3'd2, 10'd50};
    dir_cfgs[1] = '{32'h0400_0000, 32'hF800_0000, 3'd0, 10'd0};
    dir_cfgs[2] = '{32'h8000_0000, 32'h8000_0000, 3'd7, 10'd1023};
    dir_cfgs[3] = '{32'h0000_0000, 32'h0000_0000, 3'd1, 10'd1023};

    rows = '{
      // Reset setting: corners lie outside the disk.
      '{0, 10'd0,    10'd0,    1, 4'd0,  1'b1},
      '{0, 10'd1023, 10'd1023, 1, 4'd0,  1'b1},
      '{0, 10'd0,    10'd1023, 1, 4'd0,  1'b1},
      '{0, 10'd1023, 10'd0,    1, 4'd0,  1'b1},
      '{0, 10'd512,  10'd512,  0, 4'd0,  1'b0},
      '{0, 10'd512,  10'd0,    0, 4'd0,  1'b0},
      '{0, 10'd0,    10'd512,  0, 4'd0,  1'b0},
      '{0, 10'd1023, 10'd512,  0, 4'd0,  1'b0},
      '{0, 10'd511,  10'd511,  0, 4'd0,  1'b0},
      '{0, 10'd700,  10'd300,  0, 4'd0,  1'b0},
      '{0, 10'd400,  10'd650,  0, 4'd0,  1'b0},
      '{0, 10'd300,  10'd300,  0, 4'd0,  1'b0},
      // Radius zero: any nonzero z escapes; depth zero still runs two tests.
      '{1, 10'd512,  10'd512,  1, 4'd15, 1'b1},
      '{1, 10'd600,  10'd512,  1, 4'd15, 1'b1},
      '{1, 10'd0,    10'd0,    1, 4'd0,  1'b1},
      // Extreme c with the widest radius and deepest limit.
      '{2, 10'd512,  10'd512,  0, 4'd0,  1'b0},
      '{2, 10'd1023, 10'd512,  0, 4'd0,  1'b0},
      '{2, 10'd100,  10'd600,  0, 4'd0,  1'b0},
      // c of zero: the centre never escapes and runs every test.
      '{3, 10'd512,  10'd512,  1, 4'd0,  1'b0},
      '{3, 10'd1000, 10'd512,  0, 4'd0,  1'b0}
    };

    cur_cfg = dir_cfgs[0];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    cur_id = 0;
    foreach (rows[i]) begin
      if (rows[i].cfg_id != cur_id) begin
        cur_id = rows[i].cfg_id;
        load_setting(dir_cfgs[cur_id]);
      end
      send_pixel(rows[i].x, rows[i].y, rows[i].typed,
                 rows[i].color, rows[i].painted);
    end

    // Random phases; the last two run without idling on either side.
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: begin s.c_re = $urandom; s.c_im = $urandom; end
        1: begin
          s.c_re = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
          s.c_im = 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        end
        2: begin
          s.c_re = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          s.c_im = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        default: begin s.c_re = 32'hFBBA_5E34; s.c_im = 32'hF639_580E; end
      endcase
      s.radius = (ph == 0) ? 3'd7 : 3'($urandom_range(0, 7));
      s.depth  = (ph == 1) ? 10'd120 : 10'($urandom_range(0, 48));
      load_setting(s);
      idle_on = (ph < 6);
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          x = 10'($urandom); y = 10'($urandom);
        end else begin
          x = 10'($urandom_range(160, 864));
          y = 10'($urandom_range(160, 864));
        end
        send_pixel(x, y, 1'b0, 4'd0, 1'b0);
      end
    end

    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
